>>> sv/ctcgd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctcgd_pkg
// Types and constants of the greedy CTC decoder core.
// ----------------------------------------------------------------------------
package ctcgd_pkg;

  localparam int unsigned MaxClasses = 8192;
  localparam int unsigned ScoreBits  = 16;
  localparam int unsigned ClassBits  = $clog2(MaxClasses);
  localparam int unsigned CfgBits    = ClassBits + 1;
  localparam int unsigned AddrBits   = 3;
  localparam int unsigned DataBits   = 32;

  typedef logic signed [ScoreBits-1:0] score_t;
  typedef logic [ClassBits-1:0]        class_t;
  typedef logic [CfgBits-1:0]          cfg_t;
  typedef logic [AddrBits-1:0]         addr_t;
  typedef logic [DataBits-1:0]         data_t;

  localparam logic REG_NUM_CLASSES = 1'b0;
  localparam logic REG_DICT_SIZE   = 1'b1;

  localparam cfg_t NUM_CLASSES_RESET = cfg_t'(97);
  localparam cfg_t DICT_SIZE_RESET   = cfg_t'(96);
  localparam cfg_t MIN_CLASSES       = cfg_t'(2);
  localparam cfg_t MAX_CLASSES_CFG   = cfg_t'(MaxClasses);

  typedef struct packed {
    class_t char_index;
    logic   has_char;
    logic   out_of_range;
    logic   text_done;
  } result_t;

endpackage
`default_nettype wire

>>> sv/ctc_greedy_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctc_greedy_decoder_core
// Greedy best-path CTC decoder over a stream of signed Q8.8 class scores.
// ----------------------------------------------------------------------------
// One score is taken per clock cycle, back to back, class 0 first. The
// running maximum compare and the state update finish in the cycle of the
// transfer; a result, when the score closes a timestep, is held in the output
// register from the next cycle on. A new score is taken while that result
// waits, unless the output register is full and stalled. The user must write
// registers via the APB-style port while the core is idle; it is not enforced.
// ----------------------------------------------------------------------------
module ctc_greedy_decoder_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire ctcgd_pkg::addr_t  paddr,
  input  wire ctcgd_pkg::data_t  pwdata,
  output      ctcgd_pkg::data_t  prdata,
  output      logic              pready,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire ctcgd_pkg::score_t score_i,
  input  wire logic              end_of_text_i,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      ctcgd_pkg::class_t char_index_o,
  output      logic              has_char_o,
  output      logic              out_of_range_o,
  output      logic              text_done_o
);
  import ctcgd_pkg::*;

  cfg_t    num_classes_q, dict_size_q;
  score_t  best_score_q, best_score_d;
  class_t  best_class_q, best_class_d;
  class_t  class_count_q, class_count_d;
  class_t  prev_class_q, prev_class_d;
  logic    prev_valid_q, prev_valid_d;
  logic    out_valid_q, out_valid_d;
  result_t result_q, result_d;

  logic    cfg_write, in_xfer, out_xfer, step_end, fresh, emit;
  cfg_t    n_eff;
  class_t  blank;
  class_t  arg;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_NUM_CLASSES: prdata = data_t'(num_classes_q);
      REG_DICT_SIZE:   prdata = data_t'(dict_size_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_classes_q <= NUM_CLASSES_RESET;
      dict_size_q   <= DICT_SIZE_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_NUM_CLASSES) begin
        num_classes_q <= pwdata[CfgBits-1:0];
      end else begin
        dict_size_q <= pwdata[CfgBits-1:0];
      end
    end
  end

  assign out_xfer   = out_valid_q && !out_stall_i;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    if (num_classes_q < MIN_CLASSES) begin
      n_eff = MIN_CLASSES;
    end else if (num_classes_q > MAX_CLASSES_CFG) begin
      n_eff = MAX_CLASSES_CFG;
    end else begin
      n_eff = num_classes_q;
    end
  end
  assign blank = class_t'(n_eff - cfg_t'(1));

  always_comb begin
    best_score_d  = best_score_q;
    best_class_d  = best_class_q;
    class_count_d = class_count_q;
    prev_class_d  = prev_class_q;
    prev_valid_d  = prev_valid_q;
    out_valid_d   = out_valid_q && !out_xfer;
    result_d      = result_q;
    step_end      = 1'b0;
    fresh         = 1'b0;
    emit          = 1'b0;
    arg           = best_class_q;
    if (in_xfer) begin
      if (class_count_q == '0 || score_i > best_score_q) begin
        best_score_d = score_i;
        best_class_d = class_count_q;
      end
      arg      = best_class_d;
      step_end = !(class_count_q < blank) || end_of_text_i;
      if (!step_end) begin
        class_count_d = class_count_q + class_t'(1);
      end else begin
        class_count_d = '0;
        fresh         = (arg != blank) && (!prev_valid_q || arg != prev_class_q);
        prev_class_d  = arg;
        prev_valid_d  = !end_of_text_i;
        emit          = fresh || end_of_text_i;
      end
      if (emit) begin
        out_valid_d             = 1'b1;
        result_d.char_index     = fresh ? arg : '0;
        result_d.has_char       = fresh && ({1'b0, arg} < dict_size_q);
        result_d.out_of_range   = fresh && !({1'b0, arg} < dict_size_q);
        result_d.text_done      = end_of_text_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_score_q  <= '0;
      best_class_q  <= '0;
      class_count_q <= '0;
      prev_class_q  <= '0;
      prev_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      best_score_q  <= best_score_d;
      best_class_q  <= best_class_d;
      class_count_q <= class_count_d;
      prev_class_q  <= prev_class_d;
      prev_valid_q  <= prev_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign out_valid_o    = out_valid_q;
  assign char_index_o   = result_q.char_index;
  assign has_char_o     = result_q.has_char;
  assign out_of_range_o = result_q.out_of_range;
  assign text_done_o    = result_q.text_done;

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(result_q.has_char && result_q.out_of_range))
    else $error("has_char and out_of_range both set");

  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (result_q.has_char || result_q.out_of_range || result_q.text_done))
    else $error("result without character, flag or end of text");

  a_idle_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_q.has_char && !result_q.out_of_range)
      |-> (result_q.char_index == '0))
    else $error("char_index not zero without a character");

  a_eot_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && end_of_text_i) |=> (class_count_q == '0 && !prev_valid_q && out_valid_q))
    else $error("end of text did not close the sequence");

endmodule
`default_nettype wire

>>> dv/tb_ctc_greedy_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ctc_greedy_decoder_core
// Self-checking bench for the greedy CTC decoder core.
// ----------------------------------------------------------------------------
// Streams class scores through the valid/stall input and tracks the running
// argmax, blank and repeat suppression, dictionary range and end-of-text
// handling in a cycle-free predictor. Every result transfer is compared field
// by field with the oldest prediction. Registers are written and read back
// over the APB port between phases: clamped and extreme class counts, empty
// and oversized dictionaries, and a count change in the middle of a timestep.
// Both sides idle in random bursts; one long receiver hold fills the core.
// ----------------------------------------------------------------------------
module tb_ctc_greedy_decoder_core;
  import ctcgd_pkg::*;

  localparam int unsigned HoldCycles = 300;
  localparam int unsigned SettleCycles = 4;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    psel = 1'b0;
  logic    penable = 1'b0;
  logic    pwrite = 1'b0;
  addr_t   paddr = '0;
  data_t   pwdata = '0;
  data_t   prdata;
  logic    pready;
  logic    in_valid_i = 1'b0;
  logic    in_stall_o;
  score_t  score_i = '0;
  logic    end_of_text_i = 1'b0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  class_t  char_index_o;
  logic    has_char_o;
  logic    out_of_range_o;
  logic    text_done_o;

  ctc_greedy_decoder_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .score_i       (score_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .char_index_o  (char_index_o),
    .has_char_o    (has_char_o),
    .out_of_range_o(out_of_range_o),
    .text_done_o   (text_done_o)
  );

  always #4 clk_i = ~clk_i;

  // Decoder state mirror
  cfg_t        num_classes_q = NUM_CLASSES_RESET;
  cfg_t        dict_size_q = DICT_SIZE_RESET;
  score_t      top_score = '0;
  class_t      top_class = '0;
  class_t      class_pos = '0;
  class_t      last_class = '0;
  logic        last_valid = 1'b0;

  result_t     pending_results[$];
  result_t     want_result;
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned last_target = 0;
  bit          src_idling = 1'b1;
  bit          sink_idling = 1'b1;
  int unsigned hold_seq = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ERROR %s: got %0h, want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic int unsigned classes_in_use();
    int unsigned n;
    n = num_classes_q;
    if (n < MIN_CLASSES) n = MIN_CLASSES;
    if (n > MAX_CLASSES_CFG) n = MAX_CLASSES_CFG;
    return n;
  endfunction

  function automatic bit decode_score(input score_t s, input logic eot,
                                      output result_t r);
    int unsigned blank;
    logic        fresh;
    blank = classes_in_use() - 1;
    r = '0;
    if (class_pos == 0 || s > top_score) begin
      top_score = s;
      top_class = class_pos;
    end
    if (class_pos < blank && !eot) begin
      class_pos++;
      return 1'b0;
    end
    fresh = (top_class != blank) && (!last_valid || top_class != last_class);
    if (fresh) begin
      r.char_index   = top_class;
      r.has_char     = top_class < dict_size_q;
      r.out_of_range = !(top_class < dict_size_q);
    end
    r.text_done = eot;
    last_class = top_class;
    last_valid = !eot;
    class_pos = '0;
    return fresh || eot;
  endfunction

  function automatic score_t rand_score();
    case ($urandom_range(0, 3))
      0: return score_t'($urandom_range(0, 4)) - score_t'(2);
      1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return score_t'($urandom());
    endcase
  endfunction

  // Receiver: check each result transfer, then pick the next stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", char_index_o, 0);
        end else begin
          want_result = pending_results.pop_front();
          if (char_index_o !== want_result.char_index)
            report_mismatch("char_index", char_index_o, want_result.char_index);
          if (has_char_o !== want_result.has_char)
            report_mismatch("has_char", has_char_o, want_result.has_char);
          if (out_of_range_o !== want_result.out_of_range)
            report_mismatch("out_of_range", out_of_range_o, want_result.out_of_range);
          if (text_done_o !== want_result.text_done)
            report_mismatch("text_done", text_done_o, want_result.text_done);
        end
      end
      if (hold_seen != hold_seq) begin
        hold_seen <= hold_seq;
        hold_left <= HoldCycles;
        out_stall_i <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (sink_idling && $urandom_range(0, 4) == 0) begin
        stall_left <= $urandom_range(0, 3);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_score(input score_t s, input logic eot);
    result_t r;
    if (src_idling && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    score_i <= s;
    end_of_text_i <= eot;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (decode_score(s, eot, r)) pending_results = {pending_results, r};
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input data_t value);
    data_t readback;
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx == REG_NUM_CLASSES) num_classes_q = cfg_t'(value);
    else dict_size_q = cfg_t'(value);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== data_t'(cfg_t'(value)))
      report_mismatch("register readback", readback, cfg_t'(value));
  endtask

  // Four scores of one timestep, class 0 in the low bits.
  task automatic send_frame4(input logic [63:0] frame, input logic eot);
    for (int i = 0; i < 4; i++) send_score(score_t'(frame[16*i +: 16]), eot && i == 3);
  endtask

  task automatic send_timestep(input int unsigned n, input bit seq_end);
    int unsigned target;
    int unsigned cut;
    bit          targeted;
    score_t      s;
    targeted = $urandom_range(0, 3) != 0;
    case ($urandom_range(0, 3))
      0: target = n - 1;
      1: target = last_target;
      default: target = $urandom_range(0, n - 1);
    endcase
    last_target = target;
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n - 1;
    for (int unsigned i = 0; i <= cut; i++) begin
      if (!targeted) s = rand_score();
      else if (i == target) s = score_t'($urandom_range(1000, 32767));
      else s = score_t'($urandom_range(0, 1999)) - score_t'(1000);
      send_score(s, (i == cut) && (seq_end || cut != n - 1));
    end
  endtask

  task automatic test_decode_basics();
    write_reg(REG_NUM_CLASSES, 4);
    write_reg(REG_DICT_SIZE, 2);
    send_frame4(64'h0000_7FFF_7FFF_8000, 1'b0);
    send_frame4(64'h0002_0001_0005_0000, 1'b0);
    send_frame4(64'h0064_FFFF_FFFF_FFFF, 1'b0);
    send_frame4(64'h0000_0007_0000_0000, 1'b0);
    send_score(score_t'(9), 1'b0);
    send_score(score_t'(1), 1'b1);
    send_frame4(64'h0005_0005_0005_0005, 1'b0);
    send_frame4(64'h0000_0000_0000_0009, 1'b1);
  endtask

  task automatic test_register_corners();
    write_reg(REG_NUM_CLASSES, 0);
    write_reg(REG_DICT_SIZE, 0);
    for (int i = 0; i < 5; i++) send_score(rand_score(), i == 4);
    write_reg(REG_NUM_CLASSES, 32'hFFFF_FFFF);
    write_reg(REG_DICT_SIZE, 32'h0000_3FFF);
    for (int i = 0; i < 5; i++) send_score(rand_score(), i == 4);
    write_reg(REG_NUM_CLASSES, MaxClasses);
    write_reg(REG_DICT_SIZE, MaxClasses - 1);
    for (int i = 0; i < 3; i++) send_score(score_t'(i * 100), i == 2);
    write_reg(REG_NUM_CLASSES, 8);
    write_reg(REG_DICT_SIZE, 32'hFFFF_C005);
    for (int i = 0; i < 5; i++) send_score(score_t'(i), 1'b0);
    write_reg(REG_NUM_CLASSES, 3);
    for (int i = 0; i < 5; i++) send_score(rand_score(), i == 4);
    write_reg(REG_NUM_CLASSES, 1);
    write_reg(REG_DICT_SIZE, 1);
    for (int i = 0; i < 6; i++) send_score(rand_score(), i == 5);
  endtask

  task automatic test_backpressure_fill();
    write_reg(REG_NUM_CLASSES, 2);
    write_reg(REG_DICT_SIZE, MaxClasses);
    @(posedge clk_i);
    hold_seq <= hold_seq + 1;
    for (int i = 0; i < 30; i++) begin
      send_score(i[0] ? 16'sh0100 : -16'sh0100, 1'b0);
      send_score(score_t'(0), 1'b0);
    end
    wait_idle();
  endtask

  task automatic test_random_streams(input int unsigned phases, input int unsigned per_phase);
    int unsigned n_cfg;
    int unsigned stop;
    int unsigned steps;
    for (int unsigned p = 0; p < phases; p++) begin
      if (p == phases - 1) begin
        src_idling <= 1'b0;
        sink_idling <= 1'b0;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: n_cfg = $urandom_range(2, 9);
        6: n_cfg = $urandom_range(10, 40);
        7: n_cfg = NUM_CLASSES_RESET;
        8: n_cfg = $urandom_range(0, 1);
        default: n_cfg = $urandom_range(3, 6);
      endcase
      write_reg(REG_NUM_CLASSES, n_cfg);
      case ($urandom_range(0, 5))
        0: write_reg(REG_DICT_SIZE, 0);
        1: write_reg(REG_DICT_SIZE, $urandom_range(8191, 16383));
        default: write_reg(REG_DICT_SIZE, $urandom_range(1, classes_in_use() + 1));
      endcase
      stop = items_sent + per_phase;
      while (items_sent < stop) begin
        if ($urandom_range(0, 15) == 0) send_score(rand_score(), 1'b0);
        steps = $urandom_range(1, 6);
        for (int unsigned j = 0; j < steps; j++)
          send_timestep(classes_in_use(), j == steps - 1);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_decode_basics();
    test_register_corners();
    test_backpressure_fill();
    test_random_streams(9, 130);
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ctc_greedy_decoder_core: match");
    end else begin
      $display("ctc_greedy_decoder_core: mismatch");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("ctc_greedy_decoder_core: mismatch");
    $finish;
  end

endmodule

>>> files.f
sv/ctcgd_pkg.sv
sv/ctc_greedy_decoder_core.sv
dv/tb_ctc_greedy_decoder_core.sv
